// ===== sv/dasp_pkg.sv =====
// Shared types, register indexes, request codes and lookup tables for the
// dual-axis stepper positioner. No dependencies.
`default_nettype none

package dasp_pkg;

    typedef enum logic [2:0] {
        REQ_TICK        = 3'd0,
        REQ_MOVE_SLOT   = 3'd1,
        REQ_MOVE_RAW    = 3'd2,
        REQ_STEP        = 3'd3,
        REQ_STOP        = 3'd4,
        REQ_SET_POS     = 3'd5,
        REQ_RELEASE     = 3'd6,
        REQ_RELEASE_ALL = 3'd7
    } req_t;

    localparam logic [2:0] REG_X_LOW    = 3'd0;
    localparam logic [2:0] REG_X_HIGH   = 3'd1;
    localparam logic [2:0] REG_Y_LOW    = 3'd2;
    localparam logic [2:0] REG_Y_HIGH   = 3'd3;
    localparam logic [2:0] REG_INTERVAL = 3'd4;
    localparam logic [2:0] REG_RELEASE  = 3'd5;

    localparam logic [15:0] X_HIGH_RESET   = 16'd1420;
    localparam logic [15:0] Y_HIGH_RESET   = 16'd4600;
    localparam logic [15:0] INTERVAL_RESET = 16'd2;

    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_BACK = 2'b11;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] cur;
        logic [15:0] tgt;
        logic [1:0]  phase;
        logic        run;
        logic [15:0] ticks;
        logic [3:0]  nib;
    } axis_state_t;

    typedef struct packed {
        req_t        req;
        logic        sel;
        logic        slot_ok;
        logic [15:0] slot_pos;
        logic [15:0] pos;
        logic [1:0]  dir;
    } axis_cmd_t;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] interval;
        logic        rel_done;
    } axis_cfg_t;

    typedef struct packed {
        logic [7:0]  coil_pattern;
        logic        accepted;
        logic        x_busy;
        logic        y_busy;
        logic [15:0] x_position;
        logic [15:0] y_position;
    } result_t;

    function automatic logic [3:0] seq_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        unique case (phase)
            2'd0: pat = 4'h3;
            2'd1: pat = 4'h6;
            2'd2: pat = 4'hC;
            2'd3: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // entries past the known slots repeat the last one
    function automatic logic [15:0] x_slot_pos(input logic [3:0] idx);
        logic [15:0] v;
        if (idx == 4'd0) begin
            v = 16'd0;
        end else begin
            v = 16'd1420;
        end
        return v;
    endfunction

    function automatic logic [15:0] y_slot_pos(input logic [3:0] idx);
        logic [15:0] v;
        priority case (idx)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd1200;
            4'd2:    v = 16'd2300;
            4'd3:    v = 16'd3440;
            default: v = 16'd4600;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dasp_axis.sv =====
// Next-state logic for one stepper axis: tick pacing, clamped moves, stops,
// position loads, raw steps and coil release. Depends on dasp_pkg.
`default_nettype none

module dasp_axis (
    input  dasp_pkg::axis_cmd_t   cmd_i,
    input  dasp_pkg::axis_cfg_t   cfg_i,
    input  dasp_pkg::axis_state_t state_i,
    output dasp_pkg::axis_state_t state_o,
    output logic                  raw_acc_o
);

    logic [15:0] move_pos;
    logic [15:0] clamped;
    logic [15:0] ticks_inc;
    logic        do_move;
    logic        do_adv;
    logic        fwd;

    always_comb begin
        move_pos = (cmd_i.req == dasp_pkg::REQ_MOVE_SLOT) ? cmd_i.slot_pos : cmd_i.pos;
        // with inverted limits, targets below the low limit clamp low, all others high
        if ($signed(move_pos) < $signed(cfg_i.lo)) begin
            clamped = cfg_i.lo;
        end else if ($signed(move_pos) > $signed(cfg_i.hi)) begin
            clamped = cfg_i.hi;
        end else begin
            clamped = move_pos;
        end
        ticks_inc = (state_i.ticks == dasp_pkg::TICKS_MAX) ? state_i.ticks
                                                           : state_i.ticks + 16'd1;
    end

    always_comb begin
        state_o   = state_i;
        raw_acc_o = 1'b0;
        do_move   = 1'b0;
        do_adv    = 1'b0;
        fwd       = 1'b0;
        unique case (cmd_i.req)
            dasp_pkg::REQ_TICK: begin
                if (state_i.run) begin
                    if (ticks_inc < cfg_i.interval) begin
                        state_o.ticks = ticks_inc;
                    end else begin
                        state_o.ticks = 16'd0;
                        if (state_i.cur == state_i.tgt) begin
                            state_o.run = 1'b0;
                            if (cfg_i.rel_done) begin
                                state_o.nib = 4'h0;
                            end
                        end else begin
                            do_adv = 1'b1;
                            fwd    = $signed(state_i.tgt) > $signed(state_i.cur);
                        end
                    end
                end
            end
            dasp_pkg::REQ_MOVE_SLOT: begin
                do_move = cmd_i.slot_ok;
            end
            dasp_pkg::REQ_MOVE_RAW: begin
                raw_acc_o = cmd_i.sel && !state_i.run;
                do_move   = raw_acc_o;
            end
            dasp_pkg::REQ_STEP: begin
                if (cmd_i.sel) begin
                    do_adv = (cmd_i.dir == dasp_pkg::DIR_FWD) ||
                             (cmd_i.dir == dasp_pkg::DIR_BACK);
                    fwd    = (cmd_i.dir == dasp_pkg::DIR_FWD);
                end
            end
            dasp_pkg::REQ_STOP: begin
                if (cmd_i.sel) begin
                    state_o.run = 1'b0;
                    state_o.tgt = state_i.cur;
                end
            end
            dasp_pkg::REQ_SET_POS: begin
                if (cmd_i.sel) begin
                    state_o.cur = cmd_i.pos;
                    state_o.tgt = cmd_i.pos;
                    state_o.run = 1'b0;
                end
            end
            dasp_pkg::REQ_RELEASE: begin
                if (cmd_i.sel) begin
                    state_o.nib = 4'h0;
                    state_o.run = 1'b0;
                end
            end
            dasp_pkg::REQ_RELEASE_ALL: begin
                state_o.nib = 4'h0;
                state_o.run = 1'b0;
            end
        endcase

        if (do_move) begin
            state_o.tgt = clamped;
            if (state_i.cur == clamped) begin
                state_o.run = 1'b0;
            end else begin
                state_o.run   = 1'b1;
                state_o.ticks = 16'd0;
            end
        end

        if (do_adv) begin
            if (fwd) begin
                state_o.phase = state_i.phase + 2'd1;
                state_o.cur   = state_i.cur + 16'd1;
            end else begin
                state_o.phase = state_i.phase - 2'd1;
                state_o.cur   = state_i.cur - 16'd1;
            end
            state_o.nib = dasp_pkg::seq_pattern(state_o.phase);
        end
    end

endmodule

`default_nettype wire

// ===== sv/dasp_out_fifo.sv =====
// Two-entry result buffer between the positioner core and the result
// channel. Depends on dasp_pkg for the result type.
`default_nettype none

module dasp_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  dasp_pkg::result_t   wr_data,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output dasp_pkg::result_t   rd_data
);

    dasp_pkg::result_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fill_reg;
    logic              rd_en;

    assign full    = (fill_reg == 2'd2);
    assign m_valid = (fill_reg != 2'd0);
    assign rd_en   = m_valid && m_ready;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("result buffer fill out of range");

    a_fill_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("result buffer lost a transaction");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !wr_en)
        else $error("result buffer written while full");
`endif

endmodule

`default_nettype wire

// ===== sv/dual_axis_stepper_positioner.sv =====
// Dual-axis stepper positioner: one command per cycle while the result buffer
// is not full; each accepted command's result is registered into a two-entry
// result buffer. Both axes update in a single pass.
// Synchronous active-low reset clears positions, targets, phases, run flags,
// tick counters and coils, and loads the register defaults.
// Depends on dasp_pkg, dasp_axis and dasp_out_fifo.
`default_nettype none

module dual_axis_stepper_positioner #(
    parameter int X_SLOTS = 2,
    parameter int Y_SLOTS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic        s_axis,
    input  logic [3:0]  s_slot_x,
    input  logic [3:0]  s_slot_y,
    input  logic signed [15:0] s_position,
    input  logic signed [1:0]  s_step_dir,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_coil_pattern,
    output logic        m_accepted,
    output logic        m_x_busy,
    output logic        m_y_busy,
    output logic signed [15:0] m_x_position,
    output logic signed [15:0] m_y_position
);

    logic [15:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg, interval_reg;
    logic        release_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    dasp_pkg::axis_state_t x_state_reg, y_state_reg, x_next, y_next;
    dasp_pkg::axis_cmd_t   x_cmd, y_cmd;
    dasp_pkg::axis_cfg_t   x_cfg, y_cfg;
    dasp_pkg::result_t     res_next, res_out;
    dasp_pkg::req_t        req;
    logic                  slot_ok;
    logic                  x_raw_acc, y_raw_acc;
    logic                  in_accept;
    logic                  fifo_full;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg    <= 16'd0;
            x_high_reg   <= dasp_pkg::X_HIGH_RESET;
            y_low_reg    <= 16'd0;
            y_high_reg   <= dasp_pkg::Y_HIGH_RESET;
            interval_reg <= dasp_pkg::INTERVAL_RESET;
            release_reg  <= 1'b0;
        end else if (cfg_wr) begin
            priority case (cfg_idx)
                dasp_pkg::REG_X_LOW:    x_low_reg    <= pwdata[15:0];
                dasp_pkg::REG_X_HIGH:   x_high_reg   <= pwdata[15:0];
                dasp_pkg::REG_Y_LOW:    y_low_reg    <= pwdata[15:0];
                dasp_pkg::REG_Y_HIGH:   y_high_reg   <= pwdata[15:0];
                dasp_pkg::REG_INTERVAL: interval_reg <= pwdata[15:0];
                dasp_pkg::REG_RELEASE:  release_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority case (cfg_idx)
            dasp_pkg::REG_X_LOW:    prdata = {16'd0, x_low_reg};
            dasp_pkg::REG_X_HIGH:   prdata = {16'd0, x_high_reg};
            dasp_pkg::REG_Y_LOW:    prdata = {16'd0, y_low_reg};
            dasp_pkg::REG_Y_HIGH:   prdata = {16'd0, y_high_reg};
            dasp_pkg::REG_INTERVAL: prdata = {16'd0, interval_reg};
            dasp_pkg::REG_RELEASE:  prdata = {31'd0, release_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // command decode
    assign req       = dasp_pkg::req_t'(s_req_type);
    assign in_accept = s_valid && s_ready;
    assign s_ready   = !fifo_full;
    assign slot_ok   = ({1'b0, s_slot_x} < 5'(X_SLOTS)) &&
                       ({1'b0, s_slot_y} < 5'(Y_SLOTS)) &&
                       !x_state_reg.run && !y_state_reg.run;

    always_comb begin
        x_cmd.req      = req;
        x_cmd.sel      = !s_axis;
        x_cmd.slot_ok  = slot_ok;
        x_cmd.slot_pos = dasp_pkg::x_slot_pos(s_slot_x);
        x_cmd.pos      = s_position;
        x_cmd.dir      = s_step_dir;
        y_cmd          = x_cmd;
        y_cmd.sel      = s_axis;
        y_cmd.slot_pos = dasp_pkg::y_slot_pos(s_slot_y);

        x_cfg.lo       = x_low_reg;
        x_cfg.hi       = x_high_reg;
        x_cfg.interval = interval_reg;
        x_cfg.rel_done = release_reg;
        y_cfg          = x_cfg;
        y_cfg.lo       = y_low_reg;
        y_cfg.hi       = y_high_reg;
    end

    dasp_axis u_x_axis (
        .cmd_i     (x_cmd),
        .cfg_i     (x_cfg),
        .state_i   (x_state_reg),
        .state_o   (x_next),
        .raw_acc_o (x_raw_acc)
    );

    dasp_axis u_y_axis (
        .cmd_i     (y_cmd),
        .cfg_i     (y_cfg),
        .state_i   (y_state_reg),
        .state_o   (y_next),
        .raw_acc_o (y_raw_acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_state_reg <= '0;
            y_state_reg <= '0;
        end else if (in_accept) begin
            x_state_reg <= x_next;
            y_state_reg <= y_next;
        end
    end

    always_comb begin
        res_next.coil_pattern = {y_next.nib, x_next.nib};
        priority case (req)
            dasp_pkg::REQ_MOVE_SLOT: res_next.accepted = slot_ok;
            dasp_pkg::REQ_MOVE_RAW:  res_next.accepted = x_raw_acc || y_raw_acc;
            default:                 res_next.accepted = 1'b0;
        endcase
        res_next.x_busy     = x_next.run;
        res_next.y_busy     = y_next.run;
        res_next.x_position = x_next.cur;
        res_next.y_position = y_next.cur;
    end

    dasp_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (in_accept),
        .wr_data (res_next),
        .full    (fifo_full),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .rd_data (res_out)
    );

    assign m_coil_pattern = res_out.coil_pattern;
    assign m_accepted     = res_out.accepted;
    assign m_x_busy       = res_out.x_busy;
    assign m_y_busy       = res_out.y_busy;
    assign m_x_position   = res_out.x_position;
    assign m_y_position   = res_out.y_position;

`ifndef NO_ASSERTIONS
    a_slot_busy_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && req == dasp_pkg::REQ_MOVE_SLOT &&
         (x_state_reg.run || y_state_reg.run)) |-> !res_next.accepted)
        else $error("slot move accepted while an axis was running");

    a_idle_tick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && req == dasp_pkg::REQ_TICK && !x_state_reg.run)
        |=> $stable(x_state_reg))
        else $error("idle X axis changed on a tick");

    a_release_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && req == dasp_pkg::REQ_RELEASE_ALL)
        |=> (x_state_reg.nib == 4'h0 && y_state_reg.nib == 4'h0 &&
             !x_state_reg.run && !y_state_reg.run))
        else $error("release all left coils or motion active");
`endif

endmodule

`default_nettype wire
